>>> src/satt_pkg.sv
// Shared sizes, entry types and request codes for the transposition table unit.
`timescale 1ns / 1ps
package satt_pkg;

    localparam int TABLE_SETS = 1024;
    localparam int WAYS       = 4;
    localparam int KEY_W      = 32;
    localparam int DEPTH_W    = 16;
    localparam int SET_W      = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W    = KEY_W + DEPTH_W;
    localparam int ROW_W      = WAYS * ENTRY_W;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    // Outcome of comparing one set against a key
    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   hit_way;
        logic [DEPTH_W-1:0] hit_depth;
        logic [WAY_W-1:0]   victim;
    } t_way_sel;

    // Set index: low key bits under the set mask
    function automatic logic [SET_W-1:0] set_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] masked;
        masked = key & KEY_W'(TABLE_SETS - 1);
        return masked[SET_W-1:0];
    endfunction

endpackage

>>> src/satt_set_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module satt_set_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/satt_way_sel.sv
// Parallel way compare: first matching way and depth-preferred victim.
`timescale 1ns / 1ps
module satt_way_sel (
    input  satt_pkg::t_row                  i_row,
    input  logic [satt_pkg::KEY_W-1:0]      i_key,
    output satt_pkg::t_way_sel              o_sel
);
    import satt_pkg::*;

    always_comb begin
        logic [DEPTH_W-1:0] v_min;
        v_min          = i_row[0].depth;
        o_sel          = '0;
        for (int w = 0; w < WAYS; w++) begin
            // Take the lowest way holding the key
            if (!o_sel.hit && (i_row[w].key == i_key)) begin
                o_sel.hit       = 1'b1;
                o_sel.hit_way   = WAY_W'(w);
                o_sel.hit_depth = i_row[w].depth;
            end
            // Keep the shallowest way, lowest on ties
            if (i_row[w].depth < v_min) begin
                v_min        = i_row[w].depth;
                o_sel.victim = WAY_W'(w);
            end
        end
    end

endmodule

>>> src/set_assoc_transposition_table_unit.sv
// Top level: set-associative transposition table with depth-preferred replacement.
//
//  channel   | handshake              | fields
//  ----------+------------------------+-------------------------------------
//  request   | start in, busy out     | i_req_type, i_key_hash, i_new_depth
//  result    | o_done strobe out      | o_ok, o_found_depth
//
//  One request beat per cycle while busy is low; its result is registered after
//  the set RAM read, then way compare and write-back into the result register.
//  Throughput is set by the single set RAM: one read and one write per cycle,
//  with the last write forwarded to the following request on the same set.
//  After reset a clearing pass zeroes the RAM one set per cycle, through all
//  TABLE_SETS sets, with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
module set_assoc_transposition_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [satt_pkg::KEY_W-1:0]    i_key_hash,
    input  logic [satt_pkg::DEPTH_W-1:0]  i_new_depth,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [satt_pkg::DEPTH_W-1:0]  o_found_depth
);
    import satt_pkg::*;

    logic               accept;
    logic               r_clearing;
    logic [SET_W-1:0]   r_clr_set;

    logic               r_s1_vld;
    logic               r_s1_req;
    logic [KEY_W-1:0]   r_s1_key;
    logic [DEPTH_W-1:0] r_s1_depth;

    logic               r_fw_vld;
    logic [SET_W-1:0]   r_fw_set;
    t_row               r_fw_row;

    logic               r_done;
    logic               r_ok;
    logic [DEPTH_W-1:0] r_found_depth;

    logic [ROW_W-1:0]   ram_rdata;
    logic [SET_W-1:0]   s1_set;
    t_row               cur_row;
    t_row               n_row;
    t_way_sel           sel;
    logic               req_we;
    logic               n_ok;
    logic [DEPTH_W-1:0] n_found_depth;

    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    t_row               ram_wdata;

    assign busy   = r_clearing;
    assign accept = start && !busy;
    assign s1_set = set_of(r_s1_key);

    // Clearing pass and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_set  <= '0;
            r_s1_vld   <= 1'b0;
            r_fw_vld   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_set <= r_clr_set + 1'b1;
                if (r_clr_set == SET_W'(TABLE_SETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_vld <= accept;
            r_fw_vld <= ram_we;
            r_done   <= r_s1_vld;
        end
    end

    // Hold the accepted beat, the last write and the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req   <= i_req_type;
            r_s1_key   <= i_key_hash;
            r_s1_depth <= i_new_depth;
        end
        r_fw_set      <= ram_waddr;
        r_fw_row      <= ram_wdata;
        r_ok          <= n_ok;
        r_found_depth <= n_found_depth;
    end

    satt_set_ram #(
        .DEPTH (TABLE_SETS),
        .WIDTH (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (set_of(i_key_hash)),
        .o_rdata (ram_rdata)
    );

    // Forward the previous write when it hit the same set
    assign cur_row = (r_fw_vld && (r_fw_set == s1_set)) ? r_fw_row : t_row'(ram_rdata);

    satt_way_sel u_sel (
        .i_row (cur_row),
        .i_key (r_s1_key),
        .o_sel (sel)
    );

    // Lookup result, or insert/update of one way
    always_comb begin
        n_row         = cur_row;
        req_we        = 1'b0;
        n_ok          = 1'b0;
        n_found_depth = '0;
        if (r_s1_vld) begin
            if (r_s1_req == REQ_LOOKUP) begin
                n_ok          = sel.hit;
                n_found_depth = sel.hit ? sel.hit_depth : '0;
            end else if (sel.hit) begin
                if (sel.hit_depth < r_s1_depth) begin
                    n_row[sel.hit_way].depth = r_s1_depth;
                    req_we                   = 1'b1;
                    n_ok                     = 1'b1;
                end
            end else begin
                n_row[sel.victim].key   = r_s1_key;
                n_row[sel.victim].depth = r_s1_depth;
                req_we                  = 1'b1;
                n_ok                    = 1'b1;
            end
        end
    end

    // Write port: clearing pass, else request write-back
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_set;
            ram_wdata = '0;
        end else begin
            ram_we    = req_we;
            ram_waddr = s1_set;
            ram_wdata = n_row;
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_found_depth = r_found_depth;

`ifndef SYNTHESIS
    // No request in flight while the clearing pass runs
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_vld)
        else $error("request in flight during clearing pass");

    // Every result follows an accepted beat through the stage-one and result registers
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without matching request");

    // Insert results never carry a depth
    a_insert_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_s1_req == REQ_INSERT)) |-> (o_found_depth == '0))
        else $error("insert result with non-zero depth");

    // A failed result, lookup miss or refused insert, reports depth zero
    a_miss_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_found_depth == '0))
        else $error("failed result with non-zero depth");
`endif

endmodule

>>> bench/set_assoc_transposition_table_unit_tb.sv
// Bench for the transposition table unit: directed table, then random probes against a model.
`timescale 1ns / 1ps
module set_assoc_transposition_table_unit_tb;
    import satt_pkg::*;

    localparam int N_RANDOM   = 1950;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_KEYS     = 24;
    localparam int N_SLOTS    = TABLE_SETS * WAYS;

    typedef struct packed {
        logic               ok;
        logic [DEPTH_W-1:0] depth;
    } t_result;

    typedef struct {
        logic               req;
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        bit                 typed;
        t_result            res;
    } t_probe;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic [KEY_W-1:0]   i_key_hash;
    logic [DEPTH_W-1:0] i_new_depth;
    logic               o_done;
    logic               o_ok;
    logic [DEPTH_W-1:0] o_found_depth;

    // Table model and the results it still owes
    logic [KEY_W-1:0]   model_keys   [N_SLOTS];
    logic [DEPTH_W-1:0] model_depths [N_SLOTS];
    t_result            pending_results[$];
    t_probe             probe_table[$];
    logic [KEY_W-1:0]   key_pool [N_KEYS];

    bit      beat_taken;
    bit      cur_typed;
    t_result cur_res;
    int      mismatches;
    int      idle_cycles;

    set_assoc_transposition_table_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_key_hash    (i_key_hash),
        .i_new_depth   (i_new_depth),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_found_depth (o_found_depth)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result of one probe and update the model table
    function automatic t_result probe_table_model(input logic req, input logic [KEY_W-1:0] key,
                                                  input logic [DEPTH_W-1:0] depth);
        t_result r;
        int      base;
        int      victim;
        base   = int'(key & KEY_W'(TABLE_SETS - 1)) * WAYS;
        victim = 0;
        r      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (model_keys[base + w] == key) begin
                if (req == REQ_LOOKUP) begin
                    r.ok    = 1'b1;
                    r.depth = model_depths[base + w];
                end else if (model_depths[base + w] < depth) begin
                    model_depths[base + w] = depth;
                    r.ok = 1'b1;
                end
                return r;
            end
            if (model_depths[base + w] < model_depths[base + victim])
                victim = w;
        end
        if (req == REQ_INSERT) begin
            model_keys[base + victim]   = key;
            model_depths[base + victim] = depth;
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic add_probe(input logic req, input logic [KEY_W-1:0] key,
                             input logic [DEPTH_W-1:0] depth, input bit typed,
                             input logic ok, input logic [DEPTH_W-1:0] fdepth);
        t_probe p;
        p.req   = req;
        p.key   = key;
        p.depth = depth;
        p.typed = typed;
        p.res   = {ok, fdepth};
        probe_table.push_back(p);
    endtask

    // Hold one request beat until the unit takes it
    task automatic send_probe(input t_probe p);
        start       = 1'b1;
        i_req_type  = p.req;
        i_key_hash  = p.key;
        i_new_depth = p.depth;
        cur_typed   = p.typed;
        cur_res     = p.res;
        forever begin
            @(negedge i_clk);
            if (beat_taken) break;
        end
    endtask

    task automatic idle_gap(input int n);
        start = 1'b0;
        repeat (n) begin
            i_req_type  = 1'($urandom);
            i_key_hash  = $urandom;
            i_new_depth = 16'($urandom);
            @(negedge i_clk);
        end
    endtask

    function automatic t_probe random_probe();
        t_probe p;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 15)
            p.key = $urandom;
        else
            p.key = key_pool[$urandom_range(0, N_KEYS - 1)];
        r = $urandom_range(0, 99);
        if (r < 70)
            p.depth = 16'($urandom_range(0, 40));
        else if (r < 75)
            p.depth = 16'hFFFF;
        else
            p.depth = 16'($urandom);
        p.req   = $urandom_range(0, 1) ? REQ_INSERT : REQ_LOOKUP;
        p.typed = 1'b0;
        p.res   = '0;
        return p;
    endfunction

    // Check results, take request beats, watch for a hang
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        bit      took;
        took       = i_rst_n && start && !busy;
        beat_taken = took;
        if (i_rst_n) begin
            if (o_done) begin
                got = {o_ok, o_found_depth};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: ok=%0b depth=%h", o_ok, o_found_depth);
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok || got.depth !== want.depth) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected ok=%0b depth=%h, got ok=%0b depth=%h",
                                     want.ok, want.depth, got.ok, got.depth);
                    end
                end
            end
            if (took) begin
                pred = probe_table_model(i_req_type, i_key_hash, i_new_depth);
                pending_results.push_back(cur_typed ? cur_res : pred);
            end
            if (took || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int     burst_left;
        int     burst_gap;
        t_probe p;
        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_req_type  = REQ_LOOKUP;
        i_key_hash  = '0;
        i_new_depth = '0;
        cur_typed   = 1'b0;
        cur_res     = '0;
        beat_taken  = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        for (int i = 0; i < N_SLOTS; i++) begin
            model_keys[i]   = '0;
            model_depths[i] = '0;
        end

        // Keys crowded onto a few sets, so hits and evictions are common
        for (int i = 0; i < N_KEYS; i++) begin
            case (i % 6)
                0: key_pool[i] = ($urandom & ~32'h3FF);
                1: key_pool[i] = ($urandom & ~32'h3FF) | 32'h3FF;
                default: key_pool[i] = ($urandom & ~32'h3FF) | 32'(i % 6 * 97);
            endcase
        end
        key_pool[0] = 32'h0;

        // Directed probes: cleared entries, extremes, tie-break and depth rules
        add_probe(REQ_LOOKUP, 32'h0000_0000, 16'h0000, 1, 1'b1, 16'h0000);
        add_probe(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, 16'h0000);
        add_probe(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 16'hFFFF);
        add_probe(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0000, 16'h0000, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0000, 16'h0005, 1, 1'b1, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h0000_0000, 16'hFFFF, 1, 1'b1, 16'h0005);
        add_probe(REQ_INSERT, 32'h0000_0400, 16'h0007, 1, 1'b1, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0800, 16'h0003, 1, 1'b1, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0C00, 16'h0009, 1, 1'b1, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_1000, 16'h0001, 0, 1'b0, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h0000_0800, 16'h0000, 0, 1'b0, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h0000_1000, 16'h0000, 0, 1'b0, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h0000_0400, 16'h0000, 0, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0400, 16'h0006, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'h0000_0400, 16'h0008, 1, 1'b1, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h0000_0400, 16'h0000, 1, 1'b1, 16'h0008);
        add_probe(REQ_LOOKUP, 32'hAAAA_AAAA, 16'hFFFF, 1, 1'b0, 16'h0000);
        add_probe(REQ_INSERT, 32'h5555_5555, 16'h5555, 1, 1'b1, 16'h0000);
        add_probe(REQ_LOOKUP, 32'h5555_5555, 16'hAAAA, 1, 1'b1, 16'h5555);

        // Hold reset low, then release it
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the table back to back to exercise same-set forwarding
        foreach (probe_table[i])
            send_probe(probe_table[i]);

        // Random probes in bursts with gaps between them
        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    burst_left = $urandom_range(100, 200);
                    burst_gap  = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    burst_gap  = $urandom_range(0, 6);
                end
                if (burst_gap > 0)
                    idle_gap(burst_gap);
            end
            burst_left--;
            p = random_probe();
            send_probe(p);
        end
        start = 1'b0;

        // Drain, then allow the pipeline to settle
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/satt_pkg.sv
src/satt_set_ram.sv
src/satt_way_sel.sv
src/set_assoc_transposition_table_unit.sv
bench/set_assoc_transposition_table_unit_tb.sv
